FILE: rtl/core/csc_pkg.sv
// Shared types, register indexes and constants of the color sensor calibrate/classify unit.
package csc_pkg;

	localparam int unsigned RAW_W    = 16;
	localparam int unsigned LEVEL_W  = 16;
	localparam int unsigned OFFSET_W = 8;
	localparam int unsigned GAIN_W   = 16;
	localparam int unsigned GAIN_FRAC_BITS = 14;
	localparam int unsigned CODE_W   = 3;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 16;

	localparam logic [LEVEL_W-1:0] TWO_CHANNEL_LIMIT = 16'd6600;

	localparam logic [CODE_W-1:0] CODE_BLACK = 3'b000;
	localparam logic [CODE_W-1:0] CODE_WHITE = 3'b111;
	localparam logic [CODE_W-1:0] CODE_RED   = 3'b100;
	localparam logic [CODE_W-1:0] CODE_GREEN = 3'b010;
	localparam logic [CODE_W-1:0] CODE_BLUE  = 3'b001;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_RED_OFFSET   = 3'd0,
		REG_GREEN_OFFSET = 3'd1,
		REG_BLUE_OFFSET  = 3'd2,
		REG_RED_GAIN     = 3'd3,
		REG_GREEN_GAIN   = 3'd4,
		REG_BLUE_GAIN    = 3'd5,
		REG_BRIGHT_LIMIT = 3'd6,
		REG_DARK_LIMIT   = 3'd7
	} csc_reg_e;

	localparam logic [OFFSET_W-1:0] RED_OFFSET_RST   = 8'd167;
	localparam logic [OFFSET_W-1:0] GREEN_OFFSET_RST = 8'd133;
	localparam logic [OFFSET_W-1:0] BLUE_OFFSET_RST  = 8'd149;
	localparam logic [GAIN_W-1:0]   RED_GAIN_RST     = 16'd10726;
	localparam logic [GAIN_W-1:0]   GREEN_GAIN_RST   = 16'd13306;
	localparam logic [GAIN_W-1:0]   BLUE_GAIN_RST    = 16'd12119;
	localparam logic [LEVEL_W-1:0]  BRIGHT_LIMIT_RST = 16'd10000;
	localparam logic [LEVEL_W-1:0]  DARK_LIMIT_RST   = 16'd3000;

	typedef struct packed {
		logic [OFFSET_W-1:0] red_offset;
		logic [OFFSET_W-1:0] green_offset;
		logic [OFFSET_W-1:0] blue_offset;
		logic [GAIN_W-1:0]   red_gain;
		logic [GAIN_W-1:0]   green_gain;
		logic [GAIN_W-1:0]   blue_gain;
		logic [LEVEL_W-1:0]  bright_limit;
		logic [LEVEL_W-1:0]  dark_limit;
	} csc_cfg_t;

endpackage

FILE: rtl/core/csc_cfg_regs.sv
// Configuration register file: offsets, gains and brightness limits.
module csc_cfg_regs
	import csc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output csc_cfg_t              cfg
);

	csc_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.red_offset   <= RED_OFFSET_RST;
			cfg_q.green_offset <= GREEN_OFFSET_RST;
			cfg_q.blue_offset  <= BLUE_OFFSET_RST;
			cfg_q.red_gain     <= RED_GAIN_RST;
			cfg_q.green_gain   <= GREEN_GAIN_RST;
			cfg_q.blue_gain    <= BLUE_GAIN_RST;
			cfg_q.bright_limit <= BRIGHT_LIMIT_RST;
			cfg_q.dark_limit   <= DARK_LIMIT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_RED_OFFSET:   cfg_q.red_offset   <= cfg_data[OFFSET_W-1:0];
				REG_GREEN_OFFSET: cfg_q.green_offset <= cfg_data[OFFSET_W-1:0];
				REG_BLUE_OFFSET:  cfg_q.blue_offset  <= cfg_data[OFFSET_W-1:0];
				REG_RED_GAIN:     cfg_q.red_gain     <= cfg_data[GAIN_W-1:0];
				REG_GREEN_GAIN:   cfg_q.green_gain   <= cfg_data[GAIN_W-1:0];
				REG_BLUE_GAIN:    cfg_q.blue_gain    <= cfg_data[GAIN_W-1:0];
				REG_BRIGHT_LIMIT: cfg_q.bright_limit <= cfg_data[LEVEL_W-1:0];
				REG_DARK_LIMIT:   cfg_q.dark_limit   <= cfg_data[LEVEL_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: rtl/core/csc_calib.sv
// One channel of calibration: offset subtract, Q2.14 gain multiply, clamp and saturate.
module csc_calib
	import csc_pkg::*;
(
	input  logic [RAW_W-1:0]    raw,
	input  logic [OFFSET_W-1:0] offset,
	input  logic [GAIN_W-1:0]   gain,
	output logic [LEVEL_W-1:0]  level
);

	logic [RAW_W-1:0]                     diff;
	logic [RAW_W+GAIN_W-1:0]              prod;
	logic [RAW_W+GAIN_W-GAIN_FRAC_BITS-1:0] scaled;

	always_comb begin
		diff   = raw - {{(RAW_W-OFFSET_W){1'b0}}, offset};
		prod   = {{GAIN_W{1'b0}}, diff} * {{RAW_W{1'b0}}, gain};
		scaled = prod[RAW_W+GAIN_W-1:GAIN_FRAC_BITS];
		// A count at or below the offset reads as dark rather than wrapping.
		if (raw <= {{(RAW_W-OFFSET_W){1'b0}}, offset}) begin
			level = '0;
		end else if (|scaled[RAW_W+GAIN_W-GAIN_FRAC_BITS-1:LEVEL_W]) begin
			level = '1;
		end else begin
			level = scaled[LEVEL_W-1:0];
		end
	end

endmodule

FILE: rtl/core/csc_classify.sv
// Color code from brightness and the one or two largest calibrated levels.
module csc_classify
	import csc_pkg::*;
(
	input  logic [LEVEL_W-1:0] red_level,
	input  logic [LEVEL_W-1:0] green_level,
	input  logic [LEVEL_W-1:0] blue_level,
	input  logic [LEVEL_W-1:0] clear_level,
	input  logic [LEVEL_W-1:0] bright_limit,
	input  logic [LEVEL_W-1:0] dark_limit,
	output logic [CODE_W-1:0]  color_code
);

	logic [CODE_W-1:0]  first_bit;
	logic [LEVEL_W-1:0] first_val;
	logic [CODE_W-1:0]  second_bit;
	logic [LEVEL_W-1:0] best;

	always_comb begin
		// Largest level; a tie keeps the earlier channel.
		first_bit = CODE_RED;
		first_val = red_level;
		if (green_level > first_val) begin
			first_bit = CODE_GREEN;
			first_val = green_level;
		end
		if (blue_level > first_val) begin
			first_bit = CODE_BLUE;
			first_val = blue_level;
		end

		// Runner-up must be strictly above zero, otherwise red is taken.
		second_bit = CODE_RED;
		best       = '0;
		if (first_bit != CODE_RED && red_level > best) begin
			second_bit = CODE_RED;
			best       = red_level;
		end
		if (first_bit != CODE_GREEN && green_level > best) begin
			second_bit = CODE_GREEN;
			best       = green_level;
		end
		if (first_bit != CODE_BLUE && blue_level > best) begin
			second_bit = CODE_BLUE;
		end

		if (clear_level > bright_limit) begin
			color_code = CODE_WHITE;
		end else if (clear_level < dark_limit) begin
			color_code = CODE_BLACK;
		end else if (clear_level < TWO_CHANNEL_LIMIT) begin
			color_code = first_bit;
		end else begin
			color_code = first_bit | second_bit;
		end
	end

endmodule

FILE: rtl/core/color_sensor_calibrate_classify_unit.sv
// Top level of the color sensor calibrate/classify unit: three-stage pipeline.
//
// Input channel (in_valid/in_ready) carries four raw counts: raw_red, raw_green,
// raw_blue and raw_clear. Each accepted item gives exactly one result on the
// output channel (out_valid/out_ready): calibrated red, green and blue levels,
// the clear count unchanged and a 3-bit color code.
// Stage 1 registers the raw item, stage 2 holds the three gain products after
// clamping and saturation (one 16x16 multiplier per channel), stage 3 holds the
// classified result. An accepted item moves through stages 1, 2 and 3 in order,
// and out_valid rises once it is in stage 3. One item is taken every
// cycle while the receiver keeps out_ready high.
// When the receiver stalls, the result waits in stage 3 and the earlier stages
// keep filling until all three are occupied; only then does in_ready drop.
// Configuration is written through cfg_we, cfg_index and cfg_data with no wait
// and takes effect at the next edge; the user must change it only while no item
// is in flight, as the block does not enforce this. Reset (arst_n low) empties
// the pipeline and sets every configuration offset, gain and limit to default.
module color_sensor_calibrate_classify_unit
	import csc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [RAW_W-1:0]      raw_red,
	input  logic [RAW_W-1:0]      raw_green,
	input  logic [RAW_W-1:0]      raw_blue,
	input  logic [RAW_W-1:0]      raw_clear,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [LEVEL_W-1:0]    red_level,
	output logic [LEVEL_W-1:0]    green_level,
	output logic [LEVEL_W-1:0]    blue_level,
	output logic [LEVEL_W-1:0]    clear_level,
	output logic [CODE_W-1:0]     color_code
);

	csc_cfg_t cfg;

	logic v_s1, v_s2, v_s3;
	logic ready_s2, ready_s3;

	logic [RAW_W-1:0]   red_s1, green_s1, blue_s1, clear_s1;
	logic [LEVEL_W-1:0] red_cal, green_cal, blue_cal;
	logic [LEVEL_W-1:0] red_s2, green_s2, blue_s2, clear_s2;
	logic [CODE_W-1:0]  code_cal;
	logic [LEVEL_W-1:0] red_s3, green_s3, blue_s3, clear_s3;
	logic [CODE_W-1:0]  code_s3;

	csc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	assign ready_s3 = !v_s3 || out_ready;
	assign ready_s2 = !v_s2 || ready_s3;
	assign in_ready = !v_s1 || ready_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (in_ready) begin
				v_s1 <= in_valid;
			end
			if (ready_s2) begin
				v_s2 <= v_s1;
			end
			if (ready_s3) begin
				v_s3 <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			red_s1   <= raw_red;
			green_s1 <= raw_green;
			blue_s1  <= raw_blue;
			clear_s1 <= raw_clear;
		end
	end

	csc_calib u_cal_red (
		.raw    (red_s1),
		.offset (cfg.red_offset),
		.gain   (cfg.red_gain),
		.level  (red_cal)
	);

	csc_calib u_cal_green (
		.raw    (green_s1),
		.offset (cfg.green_offset),
		.gain   (cfg.green_gain),
		.level  (green_cal)
	);

	csc_calib u_cal_blue (
		.raw    (blue_s1),
		.offset (cfg.blue_offset),
		.gain   (cfg.blue_gain),
		.level  (blue_cal)
	);

	always_ff @(posedge clk) begin
		if (ready_s2 && v_s1) begin
			red_s2   <= red_cal;
			green_s2 <= green_cal;
			blue_s2  <= blue_cal;
			clear_s2 <= clear_s1;
		end
	end

	csc_classify u_classify (
		.red_level    (red_s2),
		.green_level  (green_s2),
		.blue_level   (blue_s2),
		.clear_level  (clear_s2),
		.bright_limit (cfg.bright_limit),
		.dark_limit   (cfg.dark_limit),
		.color_code   (code_cal)
	);

	always_ff @(posedge clk) begin
		if (ready_s3 && v_s2) begin
			red_s3   <= red_s2;
			green_s3 <= green_s2;
			blue_s3  <= blue_s2;
			clear_s3 <= clear_s2;
			code_s3  <= code_cal;
		end
	end

	assign out_valid   = v_s3;
	assign red_level   = red_s3;
	assign green_level = green_s3;
	assign blue_level  = blue_s3;
	assign clear_level = clear_s3;
	assign color_code  = code_s3;

	// An accepted item always lands in stage 1.
	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> v_s1)
		else $error("accepted item did not reach stage 1");

	// A stalled middle stage keeps its item.
	a_s2_holds: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && !ready_s2 |=> v_s2)
		else $error("stage 2 item lost while stalled");

	a_white: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (clear_level > cfg.bright_limit) |-> color_code == CODE_WHITE)
		else $error("bright item not classified white");

	// Between the limits and below the two-channel threshold only one bit is set.
	a_single_color: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && clear_level <= cfg.bright_limit && clear_level >= cfg.dark_limit
		&& clear_level < TWO_CHANNEL_LIMIT |-> $onehot(color_code))
		else $error("single-color code does not have exactly one bit");

endmodule
